FILE: rtl/core/tcsp_pkg.sv
package tcsp_pkg;

    localparam int HashMaxDigits = 12;
    localparam int Parts         = 3;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PREFIX = 3'd1,
        MODE_HASH   = 3'd2,
        MODE_RGB    = 3'd3,
        MODE_RGBI   = 3'd4,
        MODE_FAIL   = 3'd5
    } parse_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_RGBI      = 2'd2
    } status_t;

    localparam logic [7:0] CHAR_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'
    localparam logic [7:0] CHAR_COLON = 8'h3a;  // ':'
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_G     = 8'h67;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_I     = 8'h69;

    // Parser state after the current byte, as seen by the result logic
    typedef struct packed {
        parse_mode_t                    mode;
        logic [3:0]                     hash_count;
        logic [HashMaxDigits-1:0][3:0]  hash_nibbles;
        logic [1:0]                     comp_index;
        logic [Parts-1:0][7:0]          comp_values;
        logic [Parts-1:0]               comp_ok;
    } parse_view_t;

    // Returns {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

FILE: rtl/core/tcsp_parse.sv
module tcsp_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            char_in,
    input  logic                  is_last,
    output tcsp_pkg::parse_view_t view
);

    tcsp_pkg::parse_mode_t mode_reg, mode_next;
    logic [2:0]  prefix_pos_reg, prefix_pos_next;
    logic [3:0]  hash_count_reg, hash_count_next;
    logic [tcsp_pkg::HashMaxDigits-1:0][3:0] nibbles_reg, nibbles_next;
    logic [1:0]  comp_index_reg, comp_index_next;
    logic [1:0]  cic_reg, cic_next;
    logic [tcsp_pkg::Parts-1:0][7:0] values_reg, values_next;
    logic [tcsp_pkg::Parts-1:0] ok_reg, ok_next;
    logic        ended_reg, ended_next;

    logic [4:0]  hx;
    logic        hv;
    logic [3:0]  hn;
    logic [1:0]  k;

    assign hx = tcsp_pkg::hex_nibble(char_in);
    assign hv = hx[4];
    assign hn = hx[3:0];
    assign k  = (comp_index_reg == 2'd3) ? 2'd2 : comp_index_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        prefix_pos_next = prefix_pos_reg;
        hash_count_next = hash_count_reg;
        nibbles_next    = nibbles_reg;
        comp_index_next = comp_index_reg;
        cic_next        = cic_reg;
        values_next     = values_reg;
        ok_next         = ok_reg;
        ended_next      = ended_reg;
        if (!ended_reg)
        begin
            if (char_in == 8'd0)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                unique case (mode_reg)
                    tcsp_pkg::MODE_START:
                    begin
                        if (char_in == tcsp_pkg::CHAR_HASH)
                            mode_next = tcsp_pkg::MODE_HASH;
                        else if (char_in == tcsp_pkg::CHAR_R)
                        begin
                            mode_next       = tcsp_pkg::MODE_PREFIX;
                            prefix_pos_next = 3'd1;
                        end
                        else
                            mode_next = tcsp_pkg::MODE_FAIL;
                    end
                    tcsp_pkg::MODE_PREFIX:
                    begin
                        mode_next = tcsp_pkg::MODE_FAIL;
                        case (prefix_pos_reg)
                            3'd1:
                                if (char_in == tcsp_pkg::CHAR_G)
                                begin
                                    prefix_pos_next = 3'd2;
                                    mode_next       = tcsp_pkg::MODE_PREFIX;
                                end
                            3'd2:
                                if (char_in == tcsp_pkg::CHAR_B)
                                begin
                                    prefix_pos_next = 3'd3;
                                    mode_next       = tcsp_pkg::MODE_PREFIX;
                                end
                            3'd3:
                                if (char_in == tcsp_pkg::CHAR_COLON)
                                    mode_next = tcsp_pkg::MODE_RGB;
                                else if (char_in == tcsp_pkg::CHAR_A)
                                begin
                                    prefix_pos_next = 3'd4;
                                    mode_next       = tcsp_pkg::MODE_PREFIX;
                                end
                                else if (char_in == tcsp_pkg::CHAR_I)
                                begin
                                    prefix_pos_next = 3'd5;
                                    mode_next       = tcsp_pkg::MODE_PREFIX;
                                end
                            3'd4:
                                if (char_in == tcsp_pkg::CHAR_COLON)
                                    mode_next = tcsp_pkg::MODE_RGB;
                            3'd5:
                                if (char_in == tcsp_pkg::CHAR_COLON)
                                    mode_next = tcsp_pkg::MODE_RGBI;
                            default: ;
                        endcase
                    end
                    tcsp_pkg::MODE_HASH:
                    begin
                        if (!hv)
                            mode_next = tcsp_pkg::MODE_FAIL;
                        else
                        begin
                            for (int i = 0; i < tcsp_pkg::HashMaxDigits; i++)
                                if (hash_count_reg == 4'(i))
                                    nibbles_next[i] = hn;
                            // saturate one past the maximum so overlong strings fail
                            if (hash_count_reg < 4'(tcsp_pkg::HashMaxDigits + 1))
                                hash_count_next = hash_count_reg + 4'd1;
                        end
                    end
                    tcsp_pkg::MODE_RGB:
                    begin
                        if (cic_reg == 2'd0)
                        begin
                            for (int i = 0; i < tcsp_pkg::Parts; i++)
                                if (k == 2'(i))
                                begin
                                    if (hv)
                                    begin
                                        values_next[i] = {hn, hn};
                                        ok_next[i]     = 1'b1;
                                    end
                                    else
                                        ok_next[i] = 1'b0;
                                end
                        end
                        else if (cic_reg == 2'd1)
                        begin
                            for (int i = 0; i < tcsp_pkg::Parts; i++)
                                if (k == 2'(i) && hv && ok_reg[i])
                                    values_next[i][3:0] = hn;
                        end
                        if (char_in == tcsp_pkg::CHAR_SLASH &&
                            k < 2'(tcsp_pkg::Parts - 1))
                        begin
                            comp_index_next = k + 2'd1;
                            cic_next        = 2'd0;
                        end
                        else if (cic_reg < 2'd2)
                            cic_next = cic_reg + 2'd1;
                    end
                    tcsp_pkg::MODE_RGBI,
                    tcsp_pkg::MODE_FAIL: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tcsp_pkg::MODE_START;
            prefix_pos_reg <= 3'd0;
            hash_count_reg <= 4'd0;
            comp_index_reg <= 2'd0;
            cic_reg        <= 2'd0;
            ok_reg         <= '0;
            ended_reg      <= 1'b0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                // string done: start over for the next one
                mode_reg       <= tcsp_pkg::MODE_START;
                prefix_pos_reg <= 3'd0;
                hash_count_reg <= 4'd0;
                comp_index_reg <= 2'd0;
                cic_reg        <= 2'd0;
                ok_reg         <= '0;
                ended_reg      <= 1'b0;
            end
            else
            begin
                mode_reg       <= mode_next;
                prefix_pos_reg <= prefix_pos_next;
                hash_count_reg <= hash_count_next;
                comp_index_reg <= comp_index_next;
                cic_reg        <= cic_next;
                ok_reg         <= ok_next;
                ended_reg      <= ended_next;
            end
        end
    end

    // Digits and part values are only read once marked as written
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            nibbles_reg <= nibbles_next;
            values_reg  <= values_next;
        end
    end

    always_comb
    begin
        view.mode         = mode_next;
        view.hash_count   = hash_count_next;
        view.hash_nibbles = nibbles_next;
        view.comp_index   = comp_index_next;
        view.comp_values  = values_next;
        view.comp_ok      = ok_next;
    end

endmodule

FILE: rtl/core/tcsp_result.sv
module tcsp_result (
    input  tcsp_pkg::parse_view_t view,
    output logic [1:0]            status,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);

    logic [tcsp_pkg::HashMaxDigits-1:0][3:0] n;

    assign n = view.hash_nibbles;

    always_comb
    begin
        status = tcsp_pkg::STATUS_MALFORMED;
        red    = 8'd0;
        green  = 8'd0;
        blue   = 8'd0;
        case (view.mode)
            tcsp_pkg::MODE_HASH:
            begin
                // each part uses its first two digits, a lone digit doubled
                case (view.hash_count)
                    4'd3:
                    begin
                        status = tcsp_pkg::STATUS_OK;
                        red    = {n[0], n[0]};
                        green  = {n[1], n[1]};
                        blue   = {n[2], n[2]};
                    end
                    4'd6:
                    begin
                        status = tcsp_pkg::STATUS_OK;
                        red    = {n[0], n[1]};
                        green  = {n[2], n[3]};
                        blue   = {n[4], n[5]};
                    end
                    4'd9:
                    begin
                        status = tcsp_pkg::STATUS_OK;
                        red    = {n[0], n[1]};
                        green  = {n[3], n[4]};
                        blue   = {n[6], n[7]};
                    end
                    4'd12:
                    begin
                        status = tcsp_pkg::STATUS_OK;
                        red    = {n[0], n[1]};
                        green  = {n[4], n[5]};
                        blue   = {n[8], n[9]};
                    end
                    default: ;
                endcase
            end
            tcsp_pkg::MODE_RGB:
            begin
                if (view.comp_index == 2'(tcsp_pkg::Parts - 1) && (&view.comp_ok))
                begin
                    status = tcsp_pkg::STATUS_OK;
                    red    = view.comp_values[0];
                    green  = view.comp_values[1];
                    blue   = view.comp_values[2];
                end
            end
            tcsp_pkg::MODE_RGBI:
                status = tcsp_pkg::STATUS_RGBI;
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/terminal_color_spec_parser_core.sv
// Color spec parser: takes a color string one byte per cycle on the slave
// stream (tlast on the final byte, a zero byte ends the string early) and
// returns one result request per string on the master stream, carrying a
// status (parsed, malformed, or rgbi form not handled) and the red, green
// and blue components. Every byte goes through one pass of decode logic
// between the parser state registers and the output register, so a byte is
// taken every cycle; the result of a string appears in the cycle after its
// last byte. Only a waiting result that the sink has not taken stalls input.
module terminal_color_spec_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] status, [9:2] red, [17:10] green,
                                        // [25:18] blue, [31:26] zero
);

    tcsp_pkg::parse_view_t view;
    logic        take;
    logic [1:0]  status;
    logic [7:0]  red, green, blue;
    logic        out_valid_reg;
    logic [25:0] out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    tcsp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .char_in (s_axis_tdata),
        .is_last (s_axis_tlast),
        .view    (view)
    );

    tcsp_result u_result (
        .view   (view),
        .status (status),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && s_axis_tlast)
            out_data_reg <= {blue, green, red, status};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

FILE: tb/terminal_color_spec_parser_core_tb.sv
`timescale 1ns / 1ps

module terminal_color_spec_parser_core_tb;

    import tcsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1150;
    localparam int SINK_HOLD    = 400;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        status_t    status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct {
        bit     fixed;
        color_t value;
    } pinned_t;

    typedef struct {
        string      text;
        int         zero_at;
        bit         fixed;
        status_t    st;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } spec_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] char_in
    logic        s_axis_tlast  = 1'b0;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [1:0] status, [9:2] red, [17:10] green,
                                         // [25:18] blue, [31:26] zero

    terminal_color_spec_parser_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Color parser predictor state
    parse_mode_t scan_mode    = MODE_START;
    logic [2:0]  prefix_step  = 3'd0;
    logic [3:0]  hex_count    = 4'd0;
    logic [3:0]  hex_digits [HashMaxDigits] = '{default: 4'd0};
    logic [1:0]  chan         = 2'd0;
    logic [1:0]  chan_len     = 2'd0;
    logic [7:0]  chan_level [Parts] = '{default: 8'd0};
    logic [2:0]  chan_valid   = 3'd0;
    bit          terminated   = 1'b0;

    color_t  pending_colors [$];
    pinned_t pinned_colors [$];
    byte_q_t spec;

    int mismatches    = 0;
    int results_seen  = 0;
    int bytes_sent    = 0;
    int cycles        = 0;
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    spec_row_t directed_specs [$] = '{
        '{"#fff",              -1, 1, STATUS_OK,        8'hff, 8'hff, 8'hff},
        '{"#000000000000",     -1, 1, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"z",                  0, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"#abc",              -1, 0, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"#A1b2C3",           -1, 0, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"#123456789",        -1, 0, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"#0123456789aB",     -1, 0, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"#12345",            -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"#12g",              -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"#0123456789abc",    -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"#0123456789abcdef", -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"x",                 -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rg",                -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rgbx",              -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"r\377",             -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"RGB:1/2/3",         -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rgb:ff/00/FF",      -1, 1, STATUS_OK,        8'hff, 8'h00, 8'hff},
        '{"rgba:1/a2/3c4d",    -1, 0, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"rgb:1/2",           -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rgb://3",           -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rgb:12/34/x5",      -1, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rgb:1/2/3/4/zz",    -1, 0, STATUS_OK,        8'h00, 8'h00, 8'h00},
        '{"rgbi:0.5/1/1",      -1, 1, STATUS_RGBI,      8'h00, 8'h00, 8'h00},
        '{"rgbi:",             -1, 1, STATUS_RGBI,      8'h00, 8'h00, 8'h00},
        '{"#ff0f",              3, 1, STATUS_MALFORMED, 8'h00, 8'h00, 8'h00},
        '{"rgb:1/2/3zz",        9, 0, STATUS_OK,        8'h00, 8'h00, 8'h00}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_colors.size());
            $display("** terminal_color_spec_parser_core: FAILED **");
            $finish;
        end
    end

    // Sink: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = SINK_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic take_rgb_char(input logic [7:0] c);
        int         v;
        logic [1:0] k;
        v = hex_value(c);
        k = chan;
        if (chan_len == 2'd0)
        begin
            if (v >= 0)
            begin
                chan_level[k] = {v[3:0], v[3:0]};
                chan_valid[k] = 1'b1;
            end
            else
                chan_valid[k] = 1'b0;
        end
        else if (chan_len == 2'd1)
        begin
            if (v >= 0 && chan_valid[k])
                chan_level[k][3:0] = v[3:0];
        end
        // a slash after blue is just part of the ignored tail
        if (c == CHAR_SLASH && k < 2'(Parts - 1))
        begin
            chan     = k + 2'd1;
            chan_len = 2'd0;
        end
        else if (chan_len < 2'd2)
            chan_len++;
    endtask

    task automatic take_char(input logic [7:0] c);
        int          v;
        parse_mode_t nxt;
        case (scan_mode)
            MODE_START:
                if (c == CHAR_HASH)
                    scan_mode = MODE_HASH;
                else if (c == CHAR_R)
                begin
                    scan_mode   = MODE_PREFIX;
                    prefix_step = 3'd1;
                end
                else
                    scan_mode = MODE_FAIL;
            MODE_PREFIX:
            begin
                nxt = MODE_FAIL;
                case (prefix_step)
                    3'd1:
                        if (c == CHAR_G)
                        begin
                            prefix_step = 3'd2;
                            nxt = MODE_PREFIX;
                        end
                    3'd2:
                        if (c == CHAR_B)
                        begin
                            prefix_step = 3'd3;
                            nxt = MODE_PREFIX;
                        end
                    3'd3:
                        if (c == CHAR_COLON)
                            nxt = MODE_RGB;
                        else if (c == CHAR_A)
                        begin
                            prefix_step = 3'd4;
                            nxt = MODE_PREFIX;
                        end
                        else if (c == CHAR_I)
                        begin
                            prefix_step = 3'd5;
                            nxt = MODE_PREFIX;
                        end
                    3'd4:
                        if (c == CHAR_COLON)
                            nxt = MODE_RGB;
                    3'd5:
                        if (c == CHAR_COLON)
                            nxt = MODE_RGBI;
                    default:
                        nxt = MODE_FAIL;
                endcase
                scan_mode = nxt;
            end
            MODE_HASH:
            begin
                v = hex_value(c);
                if (v < 0)
                    scan_mode = MODE_FAIL;
                else
                begin
                    if (hex_count < 4'(HashMaxDigits))
                        hex_digits[hex_count] = v[3:0];
                    // saturate one past the longest legal form
                    if (hex_count < 4'(HashMaxDigits + 1))
                        hex_count++;
                end
            end
            MODE_RGB:
                take_rgb_char(c);
            default:
                ;
        endcase
    endtask

    // Advance the parser by one accepted byte; on the last byte queue the color
    task automatic absorb_char(input logic [7:0] c, input logic last);
        color_t     res;
        pinned_t    pin;
        int         d;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [7:0] lvl [Parts];
        if (!terminated)
        begin
            if (c == 8'h00)
                terminated = 1'b1;
            else
                take_char(c);
        end
        if (last)
        begin
            res = '{STATUS_MALFORMED, 8'h00, 8'h00, 8'h00};
            case (scan_mode)
                MODE_HASH:
                    if (hex_count == 4'd3 || hex_count == 4'd6 ||
                        hex_count == 4'd9 || hex_count == 4'd12)
                    begin
                        d = int'(hex_count) / Parts;
                        for (int k = 0; k < Parts; k++)
                        begin
                            hi = hex_digits[k * d];
                            lo = (d == 1) ? hi : hex_digits[k * d + 1];
                            lvl[k] = {hi, lo};
                        end
                        res = '{STATUS_OK, lvl[0], lvl[1], lvl[2]};
                    end
                MODE_RGB:
                    if (chan == 2'(Parts - 1) && chan_valid == 3'b111)
                        res = '{STATUS_OK, chan_level[0], chan_level[1], chan_level[2]};
                MODE_RGBI:
                    res.status = STATUS_RGBI;
                default:
                    ;
            endcase
            pin = pinned_colors.pop_front();
            pending_colors.push_back(pin.fixed ? pin.value : res);
            scan_mode   = MODE_START;
            prefix_step = 3'd0;
            hex_count   = 4'd0;
            chan        = 2'd0;
            chan_len    = 2'd0;
            chan_level  = '{default: 8'd0};
            chan_valid  = 3'd0;
            terminated  = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d, result %0d: %s got %0h want %0h",
                     cycles, results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        color_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (pending_colors.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, 32'h0);
                else
                begin
                    want = pending_colors.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch("status", m_axis_tdata[1:0], want.status);
                    if (m_axis_tdata[9:2] !== want.red)
                        report_mismatch("red", m_axis_tdata[9:2], want.red);
                    if (m_axis_tdata[17:10] !== want.green)
                        report_mismatch("green", m_axis_tdata[17:10], want.green);
                    if (m_axis_tdata[25:18] !== want.blue)
                        report_mismatch("blue", m_axis_tdata[25:18], want.blue);
                    if (m_axis_tdata[31:26] !== 6'd0)
                        report_mismatch("pad", m_axis_tdata[31:26], 32'h0);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_spec(input bit fixed, input color_t value);
        pinned_colors.push_back('{fixed, value});
        for (int i = 0; i < spec.size(); i++)
            send_byte(spec[i], i == spec.size() - 1);
    endtask

    // Hold the input until every queued color has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_phase(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            spec.push_back(t[i]);
    endtask

    task automatic add_hex(input int n);
        int v;
        for (int i = 0; i < n; i++)
        begin
            v = $urandom_range(0, 15);
            if (v < 10)
                spec.push_back(8'(int'("0") + v));
            else if ($urandom_range(0, 1) == 1)
                spec.push_back(8'(int'("a") + v - 10));
            else
                spec.push_back(8'(int'("A") + v - 10));
        end
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++)
            spec.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic make_hash();
        add_text("#");
        add_hex(3 * $urandom_range(1, 4));
    endtask

    task automatic make_rgb();
        add_text($urandom_range(0, 1) == 1 ? "rgba:" : "rgb:");
        for (int k = 0; k < Parts; k++)
        begin
            // an occasional empty part
            add_hex($urandom_range(0, 11) == 0 ? 0 : $urandom_range(1, 4));
            if (k < Parts - 1)
                spec.push_back(CHAR_SLASH);
        end
        case ($urandom_range(0, 3))
            0:
            begin
                spec.push_back(CHAR_SLASH);
                add_hex($urandom_range(1, 3));
            end
            1:
                add_noise($urandom_range(1, 3));
            default:
                ;
        endcase
    endtask

    task automatic make_random_spec();
        int pick;
        int pos;
        spec.delete();
        pick = $urandom_range(0, 99);
        if (pick < 30)
            make_hash();
        else if (pick < 65)
            make_rgb();
        else if (pick < 72)
        begin
            add_text("rgbi:");
            add_noise($urandom_range(0, 6));
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 1) == 1)
                make_hash();
            else
                make_rgb();
            pos = $urandom_range(0, spec.size() - 1);
            case ($urandom_range(0, 2))
                0: spec[pos] = 8'($urandom_range(0, 255));
                1: spec = spec[0:pos];
                default: spec.insert(pos, 8'h00);
            endcase
        end
        else
            add_noise($urandom_range(1, 8));
    endtask

    initial
    begin
        spec_row_t row;
        int        random_start;
        int        phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(24, 81);
        foreach (directed_specs[i])
        begin
            row = directed_specs[i];
            spec.delete();
            add_text(row.text);
            if (row.zero_at >= 0)
                spec[row.zero_at] = 8'h00;
            send_spec(row.fixed, '{row.st, row.r, row.g, row.b});
        end
        drain();

        random_start = bytes_sent;
        phase = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (phase == 0 && bytes_sent - random_start >= RANDOM_BYTES / 3)
            begin
                drain();
                set_phase(81, 24);
                // stall the sink while bytes keep coming
                hold_requests++;
                phase = 1;
            end
            else if (phase == 1 && bytes_sent - random_start >= 2 * RANDOM_BYTES / 3)
            begin
                drain();
                set_phase(0, 0);
                phase = 2;
            end
            make_random_spec();
            send_spec(1'b0, '{STATUS_MALFORMED, 8'h00, 8'h00, 8'h00});
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("** terminal_color_spec_parser_core: PASSED **");
        else
            $display("** terminal_color_spec_parser_core: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tcsp_pkg.sv
rtl/core/tcsp_parse.sv
rtl/core/tcsp_result.sv
rtl/core/terminal_color_spec_parser_core.sv
tb/terminal_color_spec_parser_core_tb.sv
